### design/servo_motion_ramp_regulator_defines.svh
// Assertion macros used by the regulator RTL.
`ifndef SERVO_MOTION_RAMP_REGULATOR_DEFINES_SVH
`define SERVO_MOTION_RAMP_REGULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SMRR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SMRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/smrr_pkg.sv
package smrr_pkg;

    // Command codes
    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_GUARD = 2'd2;
    localparam logic [1:0] CMD_LOAD  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_TIME_SLICE = 2'd0;
    localparam logic [1:0] REG_MAX_DIFF   = 2'd1;
    localparam logic [1:0] REG_MAX_READS  = 2'd2;

    // Configuration reset values
    localparam logic [12:0] TIME_SLICE_RST = 13'd480;
    localparam logic [15:0] MAX_DIFF_RST   = 16'd2000;
    localparam logic [7:0]  MAX_READS_RST  = 8'd3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_MOVE      = 2'd0,
        ST_AT_TARGET = 2'd1,
        ST_NO_POS    = 2'd2,
        ST_ACCEPTED  = 2'd3
    } t_status;

    // Motion constants
    localparam logic [15:0] POS_UNKNOWN = 16'hFFFF;
    localparam logic [15:0] MAX_ANGLE   = 16'd36000;
    localparam logic [15:0] PULL_BACK   = 16'd500;
    localparam logic [15:0] RAW_MAX     = 16'd1000;
    localparam logic [15:0] RAW_LIMIT   = 16'd32767;
    localparam logic [20:0] STALL_SAT   = 21'd32767;
    localparam logic [16:0] COEF_ONE    = 17'd65536;
    localparam logic [7:0]  SPEED_MAX   = 8'd240;
    localparam logic [15:0] SPEED_ROUND = 16'd5;
    // x / 10 == (x * 52429) >> 19 for any 16-bit x
    localparam logic [15:0] RECIP_TEN   = 16'd52429;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [12:0] time_slice_ms;
        logic [15:0] stall_margin;
        logic [7:0]  stall_reads;
    } t_cfg;

    // Shared multiplier operands
    typedef struct packed {
        logic [28:0] a;
        logic [16:0] b;
    } t_mul_op;

    // Per-servo motion record
    typedef struct packed {
        logic [15:0] cur;
        logic [15:0] tgt;
        logic [15:0] sl;
        logic [15:0] rr;
        logic [16:0] coef;
        logic        guard;
        logic [7:0]  cnt;
    } t_rec;

    localparam t_rec REC_RESET = '{
        cur: 16'hFFFF, tgt: 16'hFFFF, sl: 16'd0, rr: 16'd0,
        coef: 17'd0, guard: 1'b0, cnt: 8'd0
    };

    // Raw reading to centidegrees with the load clamp (x24 as shift-add)
    function automatic logic [15:0] raw_to_centideg(input logic [15:0] raw);
        logic [9:0] r;
        if (raw > RAW_LIMIT) begin
            r = 10'd0;
        end else if (raw > RAW_MAX) begin
            r = RAW_MAX[9:0];
        end else begin
            r = raw[9:0];
        end
        return {2'b0, r, 4'b0} + {3'b0, r, 3'b0};
    endfunction

    // Raw reading for the stall check: x24, saturated, no load clamp
    function automatic logic [14:0] stall_reading(input logic [15:0] raw);
        logic [20:0] v;
        v = {1'b0, raw, 4'b0} + {2'b0, raw, 3'b0};
        return (v > STALL_SAT) ? STALL_SAT[14:0] : v[14:0];
    endfunction

endpackage

### design/smrr_ram.sv
module smrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/smrr_mul.sv
module smrr_mul (
    input  logic               i_clk,
    input  smrr_pkg::t_mul_op  i_op,
    output logic [45:0]        o_prod
);

    logic [45:0] r_prod;

    // 29 x 17 unsigned product, registered
    always_ff @(posedge i_clk) begin
        r_prod <= {17'b0, i_op.a} * {29'b0, i_op.b};
    end

    assign o_prod = r_prod;

endmodule

### design/smrr_cfg.sv
module smrr_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output smrr_pkg::t_cfg     o_cfg
);

    logic [12:0] r_time_slice;
    logic [15:0] r_max_diff;
    logic [7:0]  r_max_reads;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // register writes on the access phase of a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_slice <= smrr_pkg::TIME_SLICE_RST;
            r_max_diff   <= smrr_pkg::MAX_DIFF_RST;
            r_max_reads  <= smrr_pkg::MAX_READS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                smrr_pkg::REG_TIME_SLICE: r_time_slice <= pwdata[12:0];
                smrr_pkg::REG_MAX_DIFF:   r_max_diff   <= pwdata[15:0];
                smrr_pkg::REG_MAX_READS:  r_max_reads  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb begin
        unique case (reg_idx)
            smrr_pkg::REG_TIME_SLICE: prdata = {19'b0, r_time_slice};
            smrr_pkg::REG_MAX_DIFF:   prdata = {16'b0, r_max_diff};
            smrr_pkg::REG_MAX_READS:  prdata = {24'b0, r_max_reads};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg.time_slice_ms = r_time_slice;
    assign o_cfg.stall_margin  = r_max_diff;
    assign o_cfg.stall_reads   = r_max_reads;

endmodule

### design/servo_motion_ramp_regulator.sv
// Servo motion ramp regulator.
// Command channel: an item is taken at a rising edge with start high and busy
// low; busy then stays high until the command has been carried out. The
// command fields select set target, regulate tick, set auto-stop or load
// position for one servo; motion state for every servo lives in a RAM.
// Result channel: o_done is high for exactly one cycle with servo index,
// status, new position and auto-stop flag; the receiver cannot hold it off.
// A tick that moves passes S_FETCH, S_DECIDE, S_RAMP, S_SQ, S_P1, S_LO, S_HI,
// S_MOVE and S_WRITE; a set that stores a new target passes S_FETCH, S_DECIDE,
// S_SPD and S_WRITE; everything else S_FETCH, S_DECIDE and S_WRITE. A new
// command can be taken in the o_done cycle. The moving tick is the longest: it
// has a chain of dependent products (ramp, step, coef squared, two partial
// products) on one registered 29 x 17 multiplier, and a registered RAM read.
// Configuration sits behind an APB-style port with no wait states; write it
// only while busy is low and no result is pending.
// Reset (synchronous, active low) restores the configuration defaults and
// marks every servo record as reset: position unknown, ramp and guard off.
`include "servo_motion_ramp_regulator_defines.svh"

module servo_motion_ramp_regulator #(
    parameter int SERVOS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_servo,
    input  logic [15:0] i_target_centideg,
    input  logic [7:0]  i_speed,
    input  logic [15:0] i_speed_raise,
    input  logic        i_enable,
    input  logic        i_pos_valid,
    input  logic [15:0] i_raw_pos,
    output logic        o_done,
    output logic [3:0]  o_servo_out,
    output logic [1:0]  o_status,
    output logic [15:0] o_move_pos_centideg,
    output logic        o_auto_stopped
);

    localparam int AW = (SERVOS > 1) ? $clog2(SERVOS) : 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_FETCH  = 11'b000_0000_0010,
        S_DECIDE = 11'b000_0000_0100,
        S_SPD    = 11'b000_0000_1000,
        S_RAMP   = 11'b000_0001_0000,
        S_SQ     = 11'b000_0010_0000,
        S_P1     = 11'b000_0100_0000,
        S_LO     = 11'b000_1000_0000,
        S_HI     = 11'b001_0000_0000,
        S_MOVE   = 11'b010_0000_0000,
        S_WRITE  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    smrr_pkg::t_cfg    cfg;
    smrr_pkg::t_mul_op mul_op;
    logic [45:0]       mul_prod;

    // captured command
    logic [1:0]  r_cmd;
    logic [3:0]  r_servo;
    logic [AW-1:0] r_addr;
    logic        r_inrng;
    logic [15:0] r_ang;
    logic [7:0]  r_spd;
    logic [15:0] r_raise;
    logic        r_en;
    logic        r_pv;
    logic [15:0] r_raw;

    // working record
    logic [15:0] r_cur, n_cur;
    logic [15:0] r_tgt, n_tgt;
    logic [15:0] r_sl, n_sl;
    logic [15:0] r_rr, n_rr;
    logic [16:0] r_coef, n_coef;
    logic        r_guard, n_guard;
    logic [7:0]  r_cnt, n_cnt;

    // sequencer scratch
    smrr_pkg::t_status r_status, n_status;
    logic        r_stop, n_stop;
    logic [28:0] r_p2, n_p2;
    logic [15:0] r_p1h, n_p1h;
    logic [28:0] r_acc, n_acc;
    logic [23:0] r_step, n_step;
    logic [15:0] r_move, n_move;

    // result registers
    logic              r_done;
    logic [3:0]        r_o_servo;
    smrr_pkg::t_status r_o_status;
    logic [15:0]       r_o_move;
    logic              r_o_stop;

    // RAM and valid bits
    logic [SERVOS-1:0] r_vld;
    logic              accept;
    logic              ram_we;
    logic [AW-1:0]     in_addr;
    logic [AW+3:0]     servo_wide;
    logic [$bits(smrr_pkg::t_rec)-1:0] ram_rdata;
    smrr_pkg::t_rec    rd_rec;
    smrr_pkg::t_rec    fetch_rec;
    smrr_pkg::t_rec    wr_rec;

    // decision terms
    logic [15:0]        ang_c;
    logic [7:0]         spd_c;
    logic [15:0]        spd_num;
    logic [15:0]        raw_c;
    logic               unknown;
    logic [15:0]        cur_e;
    logic [15:0]        tgt_e;
    logic               reverse;
    logic [14:0]        stall_val;
    logic signed [17:0] diff;
    logic signed [17:0] ndiff;
    logic [16:0]        adiff;
    logic               stall;
    logic [7:0]         cnt_inc;
    logic               pull;
    logic [15:0]        pull_tgt;
    logic [29:0]        csum;
    logic [16:0]        coef_grow;
    logic [46:0]        step_sum;
    logic [15:0]        gap;
    logic [15:0]        step_len;
    logic [15:0]        cur_mv;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign servo_wide = {{AW{1'b0}}, i_servo};
    assign in_addr    = servo_wide[AW-1:0];
    assign ram_we     = (r_state == S_WRITE) && r_inrng;

    // configuration registers
    smrr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // shared multiplier
    smrr_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (mul_prod)
    );

    // per-servo motion records
    smrr_ram #(
        .WIDTH ($bits(smrr_pkg::t_rec)),
        .DEPTH (SERVOS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wr_rec),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_rec    = ram_rdata;
    assign fetch_rec = r_vld[r_addr] ? rd_rec : smrr_pkg::REC_RESET;

    assign wr_rec.cur   = r_cur;
    assign wr_rec.tgt   = r_tgt;
    assign wr_rec.sl    = r_sl;
    assign wr_rec.rr    = r_rr;
    assign wr_rec.coef  = r_coef;
    assign wr_rec.guard = r_guard;
    assign wr_rec.cnt   = r_cnt;

    // set-target terms
    always_comb begin
        ang_c   = (r_ang > smrr_pkg::MAX_ANGLE) ? smrr_pkg::MAX_ANGLE : r_ang;
        if (r_spd == 8'd0) begin
            spd_c = 8'd1;
        end else if (r_spd > smrr_pkg::SPEED_MAX) begin
            spd_c = smrr_pkg::SPEED_MAX;
        end else begin
            spd_c = r_spd;
        end
        spd_num = {spd_c, 8'b0} + smrr_pkg::SPEED_ROUND;
        raw_c   = smrr_pkg::raw_to_centideg(r_raw);
        unknown = (r_cur == smrr_pkg::POS_UNKNOWN);
        cur_e   = unknown ? raw_c : r_cur;
        tgt_e   = unknown ? raw_c : r_tgt;
        reverse = (cur_e > tgt_e) != (cur_e > ang_c);
    end

    // stall check terms
    always_comb begin
        stall_val = smrr_pkg::stall_reading(r_raw);
        diff      = $signed({3'b0, stall_val}) - $signed({2'b0, r_cur});
        ndiff     = -diff;
        adiff     = diff[17] ? ndiff[16:0] : diff[16:0];
        stall     = r_guard && r_pv && (adiff > {1'b0, cfg.stall_margin});
        cnt_inc   = (r_cnt == 8'hFF) ? 8'hFF : r_cnt + 8'd1;
        pull      = stall && (cnt_inc >= cfg.stall_reads);
        if (!diff[17] && (diff != 18'sd0)) begin
            pull_tgt = ({1'b0, stall_val} >= smrr_pkg::PULL_BACK)
                     ? {1'b0, stall_val} - smrr_pkg::PULL_BACK : 16'd0;
        end else begin
            pull_tgt = {1'b0, stall_val} + smrr_pkg::PULL_BACK;
        end
    end

    // ramp, step and move terms
    always_comb begin
        csum      = {13'b0, r_coef} + {1'b0, mul_prod[28:0]};
        coef_grow = (csum > {13'b0, smrr_pkg::COEF_ONE}) ? smrr_pkg::COEF_ONE : csum[16:0];
        step_sum  = {1'b0, mul_prod} + {18'b0, r_acc};
        gap       = (r_tgt > r_cur) ? r_tgt - r_cur : r_cur - r_tgt;
        step_len  = (r_step < {8'b0, gap}) ? r_step[15:0] : gap;
        if ((step_len == 16'd0) && (gap != 16'd0)) begin
            step_len = 16'd1;
        end
        cur_mv    = (r_tgt < r_cur) ? r_cur - step_len : r_cur + step_len;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_tgt    = r_tgt;
        n_sl     = r_sl;
        n_rr     = r_rr;
        n_coef   = r_coef;
        n_guard  = r_guard;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_stop   = r_stop;
        n_p2     = r_p2;
        n_p1h    = r_p1h;
        n_acc    = r_acc;
        n_step   = r_step;
        n_move   = r_move;
        mul_op   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_cur   = fetch_rec.cur;
                n_tgt   = fetch_rec.tgt;
                n_sl    = fetch_rec.sl;
                n_rr    = fetch_rec.rr;
                n_coef  = fetch_rec.coef;
                n_guard = fetch_rec.guard;
                n_cnt   = fetch_rec.cnt;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_stop  = 1'b0;
                n_state = S_WRITE;
                if (!r_inrng) begin
                    n_status = smrr_pkg::ST_NO_POS;
                end else begin
                    unique case (r_cmd)
                        smrr_pkg::CMD_SET: begin
                            if (unknown && !r_pv) begin
                                n_status = smrr_pkg::ST_NO_POS;
                            end else begin
                                n_cur = cur_e;
                                n_tgt = tgt_e;
                                if (cur_e == ang_c) begin
                                    n_status = smrr_pkg::ST_AT_TARGET;
                                end else begin
                                    if (reverse) begin
                                        n_coef = '0;
                                    end
                                    n_tgt    = ang_c;
                                    n_rr     = r_raise;
                                    n_status = smrr_pkg::ST_ACCEPTED;
                                    mul_op.a = {13'b0, spd_num};
                                    mul_op.b = {1'b0, smrr_pkg::RECIP_TEN};
                                    n_state  = S_SPD;
                                end
                            end
                        end
                        smrr_pkg::CMD_TICK: begin
                            if (r_cur == r_tgt) begin
                                n_status = smrr_pkg::ST_AT_TARGET;
                            end else begin
                                if (r_guard && r_pv) begin
                                    n_cnt = stall ? (pull ? 8'd0 : cnt_inc) : 8'd0;
                                end
                                if (pull) begin
                                    n_tgt = pull_tgt;
                                end
                                n_stop   = pull;
                                n_status = smrr_pkg::ST_MOVE;
                                mul_op.a = {13'b0, r_rr};
                                mul_op.b = {4'b0, cfg.time_slice_ms};
                                n_state  = S_RAMP;
                            end
                        end
                        smrr_pkg::CMD_GUARD: begin
                            n_guard  = r_en;
                            n_status = smrr_pkg::ST_ACCEPTED;
                        end
                        smrr_pkg::CMD_LOAD: begin
                            if (r_pv) begin
                                n_cur    = raw_c;
                                n_tgt    = raw_c;
                                n_status = smrr_pkg::ST_ACCEPTED;
                            end else begin
                                n_status = smrr_pkg::ST_NO_POS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SPD: begin
                // (speed * 256 + 5) / 10
                n_sl    = mul_prod[34:19];
                n_state = S_WRITE;
            end
            S_RAMP: begin
                if (r_coef < smrr_pkg::COEF_ONE) begin
                    n_coef = coef_grow;
                end
                mul_op.a = {13'b0, r_sl};
                mul_op.b = {4'b0, cfg.time_slice_ms};
                n_state  = S_SQ;
            end
            S_SQ: begin
                n_p2     = mul_prod[28:0];
                mul_op.a = {12'b0, r_coef};
                mul_op.b = r_coef;
                n_state  = S_P1;
            end
            S_P1: begin
                // coef^2 split into high and low parts
                n_p1h    = mul_prod[32:17];
                mul_op.a = r_p2;
                mul_op.b = mul_prod[16:0];
                n_state  = S_LO;
            end
            S_LO: begin
                n_acc    = mul_prod[45:17];
                mul_op.a = r_p2;
                mul_op.b = {1'b0, r_p1h};
                n_state  = S_HI;
            end
            S_HI: begin
                // full product >> 40, exact
                n_step  = step_sum[46:23];
                n_state = S_MOVE;
            end
            S_MOVE: begin
                n_cur  = cur_mv;
                n_move = cur_mv;
                if (cur_mv == r_tgt) begin
                    n_coef = '0;
                end
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_WRITE);
            if (ram_we) begin
                r_vld[r_addr] <= 1'b1;
            end
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_servo <= i_servo;
            r_addr  <= in_addr;
            r_inrng <= (32'(i_servo) < SERVOS);
            r_ang   <= i_target_centideg;
            r_spd   <= i_speed;
            r_raise <= i_speed_raise;
            r_en    <= i_enable;
            r_pv    <= i_pos_valid;
            r_raw   <= i_raw_pos;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_tgt    <= n_tgt;
        r_sl     <= n_sl;
        r_rr     <= n_rr;
        r_coef   <= n_coef;
        r_guard  <= n_guard;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_stop   <= n_stop;
        r_p2     <= n_p2;
        r_p1h    <= n_p1h;
        r_acc    <= n_acc;
        r_step   <= n_step;
        r_move   <= n_move;
    end

    // result transfer
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_o_servo  <= r_servo;
            r_o_status <= r_status;
            r_o_move   <= (r_status == smrr_pkg::ST_MOVE) ? r_move : 16'd0;
            r_o_stop   <= r_stop && (r_status == smrr_pkg::ST_MOVE);
        end
    end

    assign o_done              = r_done;
    assign o_servo_out         = r_o_servo;
    assign o_status            = r_o_status;
    assign o_move_pos_centideg = r_o_move;
    assign o_auto_stopped      = r_o_stop;

    `SMRR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "accepted command did not raise busy")
    `SMRR_ASSERT_NEXT(a_write_done, i_clk, i_rst_n, r_state == S_WRITE, o_done && !busy, "write stage not followed by a result")
    `SMRR_ASSERT_SAME(a_ram_range, i_clk, i_rst_n, ram_we, r_inrng && !accept, "record write for a servo out of range")
    `SMRR_ASSERT_SAME(a_coef_range, i_clk, i_rst_n, r_state == S_MOVE, r_coef <= smrr_pkg::COEF_ONE, "ramp coefficient above one")
    `SMRR_ASSERT_SAME(a_stop_move, i_clk, i_rst_n, o_done && o_auto_stopped, o_status == smrr_pkg::ST_MOVE, "auto-stop flagged without a move")

endmodule

### tb/servo_motion_ramp_regulator_tb.sv
`timescale 1ns / 100ps

module servo_motion_ramp_regulator_tb;

    localparam int NUM_SERVOS   = 16;
    localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES = 12;   // longest command latency plus margin
    localparam int RANDOM_ITEMS = 160;   // per random phase

    // One command as presented on the input ports
    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  servo;
        logic [15:0] target;
        logic [7:0]  speed;
        logic [15:0] raise;
        logic        enable;
        logic        pos_valid;
        logic [15:0] raw;
    } t_cmd_item;

    // One result as expected on the output ports
    typedef struct packed {
        logic [3:0]        servo;
        smrr_pkg::t_status status;
        logic [15:0]       move;
        logic              stopped;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [3:0]  i_servo;
    logic [15:0] i_target_centideg;
    logic [7:0]  i_speed;
    logic [15:0] i_speed_raise;
    logic        i_enable;
    logic        i_pos_valid;
    logic [15:0] i_raw_pos;
    logic        o_done;
    logic [3:0]  o_servo_out;
    logic [1:0]  o_status;
    logic [15:0] o_move_pos_centideg;
    logic        o_auto_stopped;

    servo_motion_ramp_regulator #(
        .SERVOS(NUM_SERVOS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_servo            (i_servo),
        .i_target_centideg  (i_target_centideg),
        .i_speed            (i_speed),
        .i_speed_raise      (i_speed_raise),
        .i_enable           (i_enable),
        .i_pos_valid        (i_pos_valid),
        .i_raw_pos          (i_raw_pos),
        .o_done             (o_done),
        .o_servo_out        (o_servo_out),
        .o_status           (o_status),
        .o_move_pos_centideg(o_move_pos_centideg),
        .o_auto_stopped     (o_auto_stopped)
    );

    // Motion state as the block should hold it
    logic [15:0] servo_pos    [NUM_SERVOS];
    logic [15:0] servo_tgt    [NUM_SERVOS];
    logic [15:0] servo_sl     [NUM_SERVOS];
    logic [15:0] servo_rr     [NUM_SERVOS];
    logic [16:0] servo_coef   [NUM_SERVOS];
    logic        servo_guard  [NUM_SERVOS];
    logic [7:0]  servo_stalls [NUM_SERVOS];

    logic [12:0] cfg_slice;
    logic [15:0] cfg_max_diff;
    logic [7:0]  cfg_max_reads;

    t_cmd_item pending_cmds[$];
    t_result   expected_results[$];
    int        n_queued;
    int        n_taken;
    int        n_errors;
    int        gap_left;
    int        burst_left;
    int        idle_cycles;
    logic      taken;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Raw reading to centidegrees, with the load clamp
    function automatic logic [15:0] to_centideg(logic [15:0] raw);
        logic [15:0] c;
        c = (raw > smrr_pkg::RAW_LIMIT) ? 16'd0 :
            (raw > smrr_pkg::RAW_MAX) ? smrr_pkg::RAW_MAX : raw;
        return c * 16'd24;
    endfunction

    // Apply one command to the motion state and return its result
    function automatic t_result regulate(t_cmd_item it);
        t_result     r;
        logic [3:0]  s;
        logic [15:0] ang;
        logic [15:0] pos;
        logic [15:0] tgt;
        int          spd;
        int          rd;
        int          diff;
        int          adiff;
        int          nt;
        logic [63:0] grow;
        logic [63:0] step;
        logic [63:0] gap;
        logic [63:0] travel;
        s = it.servo;
        r.servo = s;
        r.status = smrr_pkg::ST_ACCEPTED;
        r.move = 16'd0;
        r.stopped = 1'b0;
        pos = servo_pos[s];
        tgt = servo_tgt[s];
        case (it.command)
            smrr_pkg::CMD_SET: begin
                ang = (it.target > smrr_pkg::MAX_ANGLE) ? smrr_pkg::MAX_ANGLE : it.target;
                spd = (it.speed == 8'd0) ? 1 :
                      (it.speed > smrr_pkg::SPEED_MAX) ? int'(smrr_pkg::SPEED_MAX) :
                      int'(it.speed);
                // unknown position: take the reading first, if there is one
                if (pos == smrr_pkg::POS_UNKNOWN) begin
                    if (it.pos_valid) begin
                        pos = to_centideg(it.raw);
                        tgt = pos;
                    end else begin
                        r.status = smrr_pkg::ST_NO_POS;
                    end
                end
                if (r.status == smrr_pkg::ST_ACCEPTED) begin
                    if (pos == ang) begin
                        r.status = smrr_pkg::ST_AT_TARGET;
                    end else begin
                        // reversal restarts the ramp
                        if ((pos > tgt) != (pos > ang))
                            servo_coef[s] = 17'd0;
                        tgt = ang;
                        servo_sl[s] = 16'((spd * 256 + 5) / 10);
                        servo_rr[s] = it.raise;
                    end
                end
            end
            smrr_pkg::CMD_TICK: begin
                if (pos == tgt) begin
                    r.status = smrr_pkg::ST_AT_TARGET;
                end else begin
                    // stall guard
                    if (servo_guard[s] && it.pos_valid) begin
                        rd = int'(it.raw) * 24;
                        if (rd > int'(smrr_pkg::RAW_LIMIT))
                            rd = int'(smrr_pkg::RAW_LIMIT);
                        diff = rd - int'(pos);
                        adiff = (diff < 0) ? -diff : diff;
                        if (adiff > int'(cfg_max_diff)) begin
                            if (servo_stalls[s] != 8'hFF)
                                servo_stalls[s] = servo_stalls[s] + 8'd1;
                            if (servo_stalls[s] >= cfg_max_reads) begin
                                nt = (diff > 0) ? rd - int'(smrr_pkg::PULL_BACK)
                                                : rd + int'(smrr_pkg::PULL_BACK);
                                if (nt < 0)
                                    nt = 0;
                                tgt = nt[15:0];
                                servo_stalls[s] = 8'd0;
                                r.stopped = 1'b1;
                            end
                        end else begin
                            servo_stalls[s] = 8'd0;
                        end
                    end
                    // ramp growth, saturating at 1.0
                    if (servo_coef[s] < smrr_pkg::COEF_ONE) begin
                        grow = 64'(servo_rr[s]);
                        grow = grow * 64'(cfg_slice) + 64'(servo_coef[s]);
                        servo_coef[s] = (grow > 64'(smrr_pkg::COEF_ONE))
                                      ? smrr_pkg::COEF_ONE : grow[16:0];
                    end
                    step = 64'(servo_sl[s]);
                    step = step * 64'(servo_coef[s]);
                    step = step * 64'(servo_coef[s]);
                    step = (step * 64'(cfg_slice)) >> 40;
                    gap = (tgt > pos) ? 64'(tgt - pos) : 64'(pos - tgt);
                    travel = (step < gap) ? step : gap;
                    if (travel == 64'd0 && gap != 64'd0)
                        travel = 64'd1;
                    pos = (tgt < pos) ? pos - travel[15:0] : pos + travel[15:0];
                    if (pos == tgt)
                        servo_coef[s] = 17'd0;
                    r.status = smrr_pkg::ST_MOVE;
                    r.move = pos;
                end
            end
            smrr_pkg::CMD_GUARD: begin
                servo_guard[s] = it.enable;
            end
            default: begin
                if (it.pos_valid) begin
                    pos = to_centideg(it.raw);
                    tgt = pos;
                end else begin
                    r.status = smrr_pkg::ST_NO_POS;
                end
            end
        endcase
        servo_pos[s] = pos;
        servo_tgt[s] = tgt;
        return r;
    endfunction

    task automatic flag_error(string msg);
        $display("mismatch: %s", msg);
        n_errors = n_errors + 1;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Idle gaps: mostly short, some long, with bursts of none at all
    function automatic int pick_gap();
        int sel;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (sel < 40)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Command driver
    always @(negedge i_clk) begin : cmd_driver
        t_cmd_item it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                it = pending_cmds.pop_front();
                start             <= 1'b1;
                i_command         <= it.command;
                i_servo           <= it.servo;
                i_target_centideg <= it.target;
                i_speed           <= it.speed;
                i_speed_raise     <= it.raise;
                i_enable          <= it.enable;
                i_pos_valid       <= it.pos_valid;
                i_raw_pos         <= it.raw;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor and command capture
    always @(posedge i_clk) begin : result_monitor
        t_result   want;
        t_cmd_item it;
        if (!i_rst_n) begin
            taken = 1'b0;
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("result for servo %0d with none outstanding",
                                         o_servo_out));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("servo_out", 16'(o_servo_out), 16'(want.servo));
                    compare_field("status", 16'(o_status), 16'(want.status));
                    compare_field("move_pos", o_move_pos_centideg, want.move);
                    compare_field("auto_stopped", 16'(o_auto_stopped), 16'(want.stopped));
                end
            end
            taken = start && !busy;
            if (taken) begin
                it = '{i_command, i_servo, i_target_centideg, i_speed, i_speed_raise,
                       i_enable, i_pos_valid, i_raw_pos};
                expected_results.push_back(regulate(it));
                n_taken = n_taken + 1;
            end
        end
    end

    // Watchdog on stalled traffic
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[servo_motion_ramp_regulator] ERROR");
            $finish;
        end
    end

    task automatic queue_item(t_cmd_item it);
        pending_cmds.push_back(it);
        n_queued = n_queued + 1;
    endtask

    // Unused fields of each command carry random values
    task automatic q_set(int s, logic [15:0] tgt, logic [7:0] spd, logic [15:0] raise,
                         logic valid, logic [15:0] raw);
        queue_item('{smrr_pkg::CMD_SET, s[3:0], tgt, spd, raise, 1'($urandom), valid, raw});
    endtask

    task automatic q_tick(int s, logic valid, logic [15:0] raw);
        queue_item('{smrr_pkg::CMD_TICK, s[3:0], 16'($urandom), 8'($urandom), 16'($urandom),
                     1'($urandom), valid, raw});
    endtask

    task automatic q_guard(int s, logic en);
        queue_item('{smrr_pkg::CMD_GUARD, s[3:0], 16'($urandom), 8'($urandom), 16'($urandom),
                     en, 1'($urandom), 16'($urandom)});
    endtask

    task automatic q_load(int s, logic valid, logic [15:0] raw);
        queue_item('{smrr_pkg::CMD_LOAD, s[3:0], 16'($urandom), 8'($urandom), 16'($urandom),
                     1'($urandom), valid, raw});
    endtask

    // Wait until every transfer is done, then let the block settle
    task automatic wait_idle();
        while (n_taken != n_queued || expected_results.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            smrr_pkg::REG_TIME_SLICE: cfg_slice = val[12:0];
            smrr_pkg::REG_MAX_DIFF:   cfg_max_diff = val[15:0];
            default:                  cfg_max_reads = val[7:0];
        endcase
    endtask

    task automatic configure(int slice, int max_diff, int max_reads);
        write_reg(smrr_pkg::REG_TIME_SLICE, slice);
        write_reg(smrr_pkg::REG_MAX_DIFF, max_diff);
        write_reg(smrr_pkg::REG_MAX_READS, max_reads);
    endtask

    function automatic logic [15:0] pick_raw();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 16'($urandom_range(0, 1500));
        if (sel < 8)
            return 16'($urandom_range(0, 32767));
        return 16'($urandom);
    endfunction

    // Mostly sensible motion traffic on a few servos, some noise elsewhere
    task automatic random_phase(int n);
        int          s;
        int          sel;
        logic [15:0] tgt;
        logic [15:0] raise;
        for (int k = 0; k < 4; k++) begin
            q_load(k, 1'b1, 16'($urandom_range(0, 1000)));
            q_guard(k, 1'($urandom));
        end
        for (int k = 0; k < n; k++) begin
            s = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                q_tick(s, $urandom_range(0, 9) < 7, pick_raw());
            end else if (sel < 75) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: tgt = 16'($urandom_range(0, 36000));
                    6, 7:             tgt = 16'($urandom_range(0, 2000));
                    default:          tgt = 16'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0, 1:             raise = 16'd0;
                    2, 3, 4, 5:       raise = 16'($urandom_range(0, 255));
                    default:          raise = 16'($urandom);
                endcase
                q_set(s, tgt, 8'($urandom), raise, 1'($urandom), pick_raw());
            end else if (sel < 87) begin
                q_load(s, $urandom_range(0, 9) != 0, 16'($urandom));
            end else begin
                q_guard(s, $urandom_range(0, 9) < 7);
            end
        end
        wait_idle();
    endtask

    // Stimulus
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 32'd0;
        start = 1'b0;
        i_command = smrr_pkg::CMD_TICK;
        i_servo = 4'd0;
        i_target_centideg = 16'd0;
        i_speed = 8'd0;
        i_speed_raise = 16'd0;
        i_enable = 1'b0;
        i_pos_valid = 1'b0;
        i_raw_pos = 16'd0;
        n_queued = 0;
        n_taken = 0;
        n_errors = 0;
        gap_left = 0;
        burst_left = 0;
        idle_cycles = 0;
        taken = 1'b0;
        for (int k = 0; k < NUM_SERVOS; k++) begin
            servo_pos[k] = smrr_pkg::POS_UNKNOWN;
            servo_tgt[k] = smrr_pkg::POS_UNKNOWN;
            servo_sl[k] = 16'd0;
            servo_rr[k] = 16'd0;
            servo_coef[k] = 17'd0;
            servo_guard[k] = 1'b0;
            servo_stalls[k] = 8'd0;
        end
        cfg_slice = smrr_pkg::TIME_SLICE_RST;
        cfg_max_diff = smrr_pkg::MAX_DIFF_RST;
        cfg_max_reads = smrr_pkg::MAX_READS_RST;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset configuration
        q_tick(0, 1'b0, 16'd0);                                  // unknown position, idle
        q_set(0, 16'd1000, 8'd100, 16'd100, 1'b0, 16'd0);        // set with no position
        q_load(1, 1'b0, 16'd0);                                  // load with no reading
        q_set(0, 16'hFFFF, 8'd0, 16'hFFFF, 1'b1, 16'd40000);     // over-range reading, clamps
        q_tick(0, 1'b1, 16'hFFFF);
        q_set(0, 16'd0, 8'd255, 16'h8000, 1'b0, 16'd0);          // reversal clears ramp
        q_tick(0, 1'b0, 16'd0);
        q_load(2, 1'b1, 16'd32767);                              // largest reading still taken
        q_set(2, 16'd24000, 8'd50, 16'd1, 1'b0, 16'd0);          // already at target
        q_set(2, 16'd100, 8'd240, 16'd0, 1'b0, 16'd0);
        q_tick(2, 1'b0, 16'd0);                                  // no ramp, minimum step
        q_guard(2, 1'b1);
        q_tick(2, 1'b1, 16'd0);
        q_tick(2, 1'b1, 16'd0);
        q_tick(2, 1'b1, 16'd0);                                  // third stall pulls back
        q_load(3, 1'b1, 16'd32768);
        q_load(3, 1'b1, 16'd1001);
        q_guard(3, 1'b0);
        q_tick(3, 1'b1, 16'hFFFF);
        wait_idle();

        // Directed: pull-back below zero lands on the current position
        configure(1, 0, 1);
        q_load(4, 1'b1, 16'd0);
        q_set(4, 16'd1000, 8'd240, 16'hFFFF, 1'b1, 16'h5555);
        q_guard(4, 1'b1);
        q_tick(4, 1'b1, 16'd1);
        random_phase(RANDOM_ITEMS);

        configure(8191, 36000, 255);
        random_phase(RANDOM_ITEMS);

        configure(0, 100, 0);
        random_phase(RANDOM_ITEMS);

        configure(20, 500, 2);
        random_phase(RANDOM_ITEMS);

        configure(int'(smrr_pkg::TIME_SLICE_RST), int'(smrr_pkg::MAX_DIFF_RST),
                  int'(smrr_pkg::MAX_READS_RST));
        random_phase(RANDOM_ITEMS);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (n_errors == 0)
            $display("[servo_motion_ramp_regulator] OK");
        else
            $display("[servo_motion_ramp_regulator] ERROR");
        $finish;
    end

endmodule
